>>> rtl/rsiu_pkg.sv
// ----------------------------------------------------------------------------
// rsiu_pkg
// Shared types and codes for the rational set insert-unique core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsiu_pkg;

   localparam int unsigned VAL_W    = 32;
   localparam int unsigned PROD_W   = 2 * VAL_W;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_ZERO_DEN = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_FINISH
   } state_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

endpackage

`default_nettype wire

>>> rtl/rational_set_insert_unique_core.sv
// ----------------------------------------------------------------------------
// rational_set_insert_unique_core
// Bounded set of fractions with insert-if-absent and membership query.
// ----------------------------------------------------------------------------
// Each beat carries an insert or a query of one fraction. The core walks the
// stored entries one per cycle through a single cross-product comparator
// (entry read, two 32x32 products, 64-bit compare), so fractions of equal value
// in any form match. An item is accepted, each stored entry is then read,
// multiplied and compared in turn, and the result is posted. A match ends the
// walk early; with an empty set or a zero denominator no entry is walked. The
// core takes one item at a time. The result sits in an output register while
// the core returns to idle. A result that has not been taken holds the next
// item in its posting cycle.
`default_nettype none

module rational_set_insert_unique_core #(
   parameter int unsigned SET_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_kind,
   input  wire logic signed [rsiu_pkg::VAL_W-1:0] req_numerator,
   input  wire logic signed [rsiu_pkg::VAL_W-1:0] req_denominator,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [rsiu_pkg::STATUS_W-1:0]     rsp_status,
   output      logic [rsiu_pkg::COUNT_W-1:0]      rsp_element_count
);

   localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);
   localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int unsigned ENT_W = 2 * rsiu_pkg::VAL_W;
   localparam int unsigned PROD_W = rsiu_pkg::PROD_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

   rsiu_pkg::state_type state_ff, state_in;

   logic                              kind_ff, kind_in;
   logic signed [rsiu_pkg::VAL_W-1:0] num_ff, num_in;
   logic signed [rsiu_pkg::VAL_W-1:0] den_ff, den_in;
   logic                              den_zero_ff, den_zero_in;
   logic                              found_ff, found_in;
   logic [CNT_W-1:0]                  issue_ff, issue_in;
   logic [CNT_W-1:0]                  fill_ff, fill_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic                              mul_vld_ff, mul_vld_in;
   logic signed [rsiu_pkg::PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [ENT_W-1:0]                  rd_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsiu_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [rsiu_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [ENT_W-1:0]                  store_mem [SET_DEPTH];
   logic                              wr_en;
   logic [CNT_W+rsiu_pkg::COUNT_W-1:0] fill_wide;

   logic accept;
   logic issuing;
   logic hit;
   logic walk_done;
   logic post;

   assign accept  = req_valid && req_ready;
   assign hit     = (state_ff == rsiu_pkg::FSM_WALK) && mul_vld_ff && (prod_a_ff == prod_b_ff);
   assign issuing = (state_ff == rsiu_pkg::FSM_WALK) && !den_zero_ff && !found_ff && !hit
                    && (issue_ff < fill_ff);
   assign walk_done = den_zero_ff || found_ff
                      || ((issue_ff >= fill_ff) && !rd_vld_ff && !mul_vld_ff);
   assign post    = !rsp_valid_ff || rsp_ready;

   // entry memory: {numerator, denominator}
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[fill_ff[IDX_W-1:0]] <= {num_ff, den_ff};
      end
      rd_data_ff <= store_mem[issue_ff[IDX_W-1:0]];
   end

   // cross products: stored n times item d, item n times stored d
   always_ff @(posedge clock) begin
      prod_a_ff <= PROD_W'($signed(rd_data_ff[ENT_W-1:rsiu_pkg::VAL_W]))
                   * PROD_W'(den_ff);
      prod_b_ff <= PROD_W'(num_ff)
                   * PROD_W'($signed(rd_data_ff[rsiu_pkg::VAL_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsiu_pkg::FSM_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         den_zero_ff  <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         found_ff     <= found_in;
         den_zero_ff  <= den_zero_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      den_zero_in   = den_zero_ff;
      found_in      = found_ff || hit;
      issue_in      = issuing ? issue_ff + 1'b1 : issue_ff;
      fill_in       = fill_ff;
      rd_vld_in     = issuing;
      mul_vld_in    = rd_vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      req_ready     = 1'b0;
      fill_wide     = '0;

      unique case (state_ff)
         rsiu_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               kind_in     = req_kind;
               num_in      = req_numerator;
               den_in      = req_denominator;
               den_zero_in = (req_denominator == '0);
               found_in    = 1'b0;
               issue_in    = '0;
               state_in    = rsiu_pkg::FSM_WALK;
            end
         end
         rsiu_pkg::FSM_WALK: begin
            if (walk_done) begin
               state_in = rsiu_pkg::FSM_FINISH;
            end
         end
         rsiu_pkg::FSM_FINISH: begin
            if (post) begin
               priority if (den_zero_ff) begin
                  rsp_status_in = rsiu_pkg::ST_ZERO_DEN;
               end else if (found_ff) begin
                  rsp_status_in = rsiu_pkg::ST_PRESENT;
               end else if (kind_ff == rsiu_pkg::KIND_QUERY) begin
                  rsp_status_in = rsiu_pkg::ST_ABSENT;
               end else if (fill_ff >= DEPTH_CNT) begin
                  rsp_status_in = rsiu_pkg::ST_FULL;
               end else begin
                  rsp_status_in = rsiu_pkg::ST_INSERTED;
                  wr_en         = 1'b1;
                  fill_in       = fill_ff + 1'b1;
               end
               fill_wide    = {{rsiu_pkg::COUNT_W{1'b0}}, fill_in};
               rsp_count_in = fill_wide[rsiu_pkg::COUNT_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = rsiu_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = rsiu_pkg::FSM_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("fill count beyond set depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rsiu_pkg::FSM_FINISH)
      else $error("result posted outside finish");

   a_fill_on_insert: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         (rsp_valid_ff && rsp_status_ff == rsiu_pkg::ST_INSERTED
          && fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill count changed without insert");
`endif

endmodule

`default_nettype wire
